>>> src/fmr_pkg.sv
// Package: shared types and constants of the frame message reassembler.
`timescale 1ns / 1ps
`default_nettype none
package fmr_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned IdW        = 29;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned CntW       = $clog2(FrameBytes + 1);
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam logic [IdW-1:0] RxIdReset = IdW'(2);

  typedef struct packed {
    logic [IdW-1:0] frame_id;
    logic [7:0]     byte_0;
    logic [7:0]     byte_1;
    logic [7:0]     byte_2;
    logic [7:0]     byte_3;
    logic [7:0]     byte_4;
    logic [7:0]     byte_5;
    logic [7:0]     byte_6;
    logic [7:0]     byte_7;
  } frame_t;

  typedef struct packed {
    logic             is_header;
    logic [SizeW-1:0] message_size;
    logic [7:0]       payload_byte;
    logic             end_of_message;
    logic             end_of_frame;
  } result_t;

  // Decoded frame handed to the serialiser.
  typedef struct packed {
    logic [CntW-1:0]                 count;
    logic                            is_header;
    logic [SizeW-1:0]                size;
    logic                            eom;
    logic [FrameBytes-1:0][7:0]      bytes;
  } load_t;

endpackage
`default_nettype wire

>>> src/fmr_decode.sv
// Frame decoder: identifier match, header/data role and remaining-length state.
`timescale 1ns / 1ps
`default_nettype none
module fmr_decode (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fmr_pkg::IdW-1:0]     cfg_wdata_i,
  input  wire fmr_pkg::frame_t             frame_i,
  input  wire logic                        accept_i,
  output fmr_pkg::load_t                   load_o,
  output logic                             match_o
);

  logic [fmr_pkg::IdW-1:0]   rxid_q;
  logic                      awaiting_q, awaiting_d;
  logic [fmr_pkg::SizeW-1:0] rem_q, rem_d;
  logic                      hdr;
  logic                      short_last;
  logic [fmr_pkg::CntW-1:0]  n;
  logic [fmr_pkg::SizeW-1:0] size;

  assign match_o = (frame_i.frame_id == rxid_q);
  assign hdr     = awaiting_q || (rem_q == '0);
  assign size    = {frame_i.byte_0, frame_i.byte_1, frame_i.byte_2, frame_i.byte_3};
  assign short_last = (rem_q <= fmr_pkg::SizeW'(fmr_pkg::FrameBytes));
  assign n = short_last ? rem_q[fmr_pkg::CntW-1:0] : fmr_pkg::CntW'(fmr_pkg::FrameBytes);

  always_comb begin
    load_o.count     = hdr ? fmr_pkg::CntW'(1) : n;
    load_o.is_header = hdr;
    load_o.size      = size;
    load_o.eom       = !hdr && short_last;
    load_o.bytes     = {frame_i.byte_7, frame_i.byte_6, frame_i.byte_5, frame_i.byte_4,
                        frame_i.byte_3, frame_i.byte_2, frame_i.byte_1, frame_i.byte_0};
    if (hdr) begin
      rem_d      = size;
      awaiting_d = (size == '0);
    end else begin
      rem_d      = rem_q - fmr_pkg::SizeW'(n);
      awaiting_d = short_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rxid_q     <= fmr_pkg::RxIdReset;
      awaiting_q <= 1'b1;
      rem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        rxid_q <= cfg_wdata_i;
      end
      if (accept_i && match_o) begin
        awaiting_q <= awaiting_d;
        rem_q      <= rem_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/fmr_serial.sv
// Result serialiser: holds one decoded frame and emits its words one per cycle while out_ready_i is high.
`timescale 1ns / 1ps
`default_nettype none
module fmr_serial (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire fmr_pkg::load_t  load_data_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fmr_pkg::result_t     out_result_o
);

  logic [fmr_pkg::CntW-1:0]               cnt_q, cnt_d;
  logic [fmr_pkg::IdxW-1:0]               idx_q;
  logic [fmr_pkg::FrameBytes-1:0][7:0]    bytes_q;
  logic                                   hdr_q, eom_q;
  logic [fmr_pkg::SizeW-1:0]              size_q;
  logic                                   take;
  logic                                   last;

  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && out_ready_i;
  assign last        = (cnt_q == fmr_pkg::CntW'(1));
  assign free_o      = (cnt_q == '0) || (last && out_ready_i);

  always_comb begin
    out_result_o.is_header      = hdr_q;
    out_result_o.message_size   = hdr_q ? size_q : '0;
    out_result_o.payload_byte   = hdr_q ? 8'h00 : bytes_q[idx_q];
    out_result_o.end_of_message = last && eom_q && !hdr_q;
    out_result_o.end_of_frame   = last;
    if (load_i) begin
      cnt_d = load_data_i.count;
    end else if (take) begin
      cnt_d = cnt_q - fmr_pkg::CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (load_i) begin
        idx_q <= '0;
      end else if (take) begin
        idx_q <= idx_q + fmr_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= load_data_i.bytes;
      hdr_q   <= load_data_i.is_header;
      eom_q   <= load_data_i.eom;
      size_q  <= load_data_i.size;
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fmr_pkg::CntW'(fmr_pkg::FrameBytes))
    else $error("word count exceeds frame size");
  a_hdr_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q && out_valid_o) |-> last)
    else $error("header frame holds more than one word");
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == '0) || (last && take)))
    else $error("load while words still pending");
  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_valid_o)
    else $error("loaded frame gives no word");

endmodule
`default_nettype wire

>>> src/frame_message_reassembler.sv
// Top level: frame message reassembler.
// Latency: a matching frame shows its first word in the cycle after acceptance.
// Throughput: one word per cycle while out_ready_i is high; a matching frame gives 1 to 8 words,
// and the next frame is taken as its last word leaves the single serialiser stage.
// Frames with another identifier are taken when the serialiser is free and give no word.
// Reset: asynchronous, active low; receive identifier 2, expecting a header, nothing held.
`timescale 1ns / 1ps
`default_nettype none
module frame_message_reassembler (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [fmr_pkg::IdW-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire fmr_pkg::frame_t         in_frame_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output fmr_pkg::result_t             out_result_o
);

  fmr_pkg::load_t load;
  logic           match;
  logic           free;
  logic           accept;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  fmr_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (in_frame_i),
    .accept_i    (accept),
    .load_o      (load),
    .match_o     (match)
  );

  fmr_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept && match),
    .load_data_i  (load),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o)
  );

endmodule
`default_nettype wire
